/* rtl/scoped_reference_interning_table_assert.svh */
// assertion macros for the scoped reference interning table
`ifndef SCOPED_REFERENCE_INTERNING_TABLE_ASSERT_SVH
`define SCOPED_REFERENCE_INTERNING_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, quiet during reset
`define SRIT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SRIT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRIT_ASSERT_NOW(label, ante, cons, msg)
`define SRIT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/srit_pkg.sv */
// shared constants and codes for the scoped reference interning table
package srit_pkg;

   localparam int ENTRIES  = 64;
   localparam int SCOPES   = 8;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int LVL_W    = (SCOPES > 1) ? $clog2(SCOPES) : 1;
   localparam int REF_W    = 64;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;

   localparam logic [MODE_W-1:0] MODE_INTERN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RES_CHK = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RES     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_POP     = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd4;

   // the "no reference" marker, all ones
   localparam logic [REF_W-1:0] REF_NONE = {REF_W{1'b1}};

endpackage

/* rtl/srit_if.sv */
// request and response channel interfaces
interface srit_req_if;
   import srit_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [REF_W-1:0]  ref_value;
   logic signed [REF_W-1:0]  read_side;

   modport source (output valid, output mode, output ref_value, output read_side,
                   input ready);
   modport sink   (input valid, input mode, input ref_value, input read_side,
                   output ready);
endinterface

interface srit_rsp_if;
   import srit_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [REF_W-1:0]  result_ref;
   logic                     was_new;
   logic [STATUS_W-1:0]      status;
   logic                     failed;

   modport source (output valid, output result_ref, output was_new, output status,
                   output failed, input ready);
   modport sink   (input valid, input result_ref, input was_new, input status,
                   input failed, output ready);
endinterface

/* rtl/scoped_reference_interning_table.sv */
// top level of the scoped reference interning table
// Scoped table that maps 64-bit references to dense identifiers. Six request modes: intern,
// checked resolve, plain resolve, add pair, push scope and pop scope. Keys and identifiers
// live in two memories of ENTRIES words shared by all scopes, each with one read and one
// write port; only the top scope is searched. Every lookup walks the top scope one entry
// per cycle through one shared comparator, so the time from acceptance to response of an
// intern, add or resolve grows with the number of entries in the top scope (at most
// ENTRIES); the memory read data is registered before the compare. Push, pop, resolve
// of -1 and unused modes skip the scan and go straight to the response state. One request
// is in flight at a time; a finished response sits in an output register, so the next
// request can be taken while it waits. No clearing pass is needed after reset: only
// entries below the fill pointer are ever read.
`include "scoped_reference_interning_table_assert.svh"

module scoped_reference_interning_table (
   input  logic       clock,
   input  logic       reset,
   srit_req_if.sink   req_ch,
   srit_rsp_if.source rsp_ch
);
   import srit_pkg::*;

   // one-hot sequencer states
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   // key and identifier memories, undefined until written
   logic [REF_W-1:0] key_mem [ENTRIES];
   logic [REF_W-1:0] id_mem  [ENTRIES];

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [CNT_W-1:0]   scope_base_ff [SCOPES];
   logic [CNT_W-1:0]   scope_base_in [SCOPES];
   logic               failed_ff, failed_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [REF_W-1:0]        val_ff, val_in;
   logic [REF_W-1:0]        side_ff, side_in;
   logic [CNT_W-1:0]        base_ff, base_in;
   logic [CNT_W-1:0]        scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic signed [REF_W-1:0] best_ff, best_in;
   logic [REF_W-1:0]        res_ff, res_in;
   logic                    new_ff, new_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [REF_W-1:0]        rsp_res_ff, rsp_res_in;
   logic                    rsp_new_ff, rsp_new_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_failed_ff, rsp_failed_in;

   // registered memory read data
   logic [REF_W-1:0] key_rd_ff;
   logic [REF_W-1:0] id_rd_ff;

   // memory access controls
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             key_we;
   logic             id_we;
   logic [IDX_W-1:0] wr_addr;
   logic [REF_W-1:0] key_wdata;
   logic [REF_W-1:0] id_wdata;

   // shared compare unit and helpers
   logic             accept;
   logic             is_resolve;
   logic             is_intern;
   logic [REF_W-1:0] cmp_a;
   logic             cmp_eq;
   logic             key_less;
   logic             more_to_read;
   logic             scan_done;
   logic [REF_W-1:0] next_id;

   assign accept     = req_ch.valid && req_ch.ready;
   assign is_resolve = (mode_ff == MODE_RES_CHK) || (mode_ff == MODE_RES);
   assign is_intern  = (mode_ff == MODE_INTERN);

   // resolve compares the stored identifier, intern and add compare the key
   assign cmp_a    = is_resolve ? id_rd_ff : key_rd_ff;
   assign cmp_eq   = (cmp_a == val_ff);
   assign key_less = $signed(key_rd_ff) < best_ff;

   assign more_to_read = (scan_ptr_ff < fill_ff);
   assign scan_done    = !rd_vld_ff && !more_to_read;

   // next identifier is the entry count of the top scope
   assign next_id = REF_W'(fill_ff - base_ff);

   assign rd_addr = scan_ptr_ff[IDX_W-1:0];

   // ready whenever no request is in flight, even with a response still waiting
   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.result_ref = rsp_res_ff;
   assign rsp_ch.was_new    = rsp_new_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.failed     = rsp_failed_ff;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      level_in      = level_ff;
      scope_base_in = scope_base_ff;
      failed_in     = failed_ff;
      rd_vld_in     = rd_vld_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      val_in        = val_ff;
      side_in       = side_ff;
      base_in       = base_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_idx_in     = rd_idx_ff;
      best_in       = best_ff;
      res_in        = res_ff;
      new_in        = new_ff;
      status_in     = status_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_status_in = rsp_status_ff;
      rsp_failed_in = rsp_failed_ff;
      rd_en         = 1'b0;
      key_we        = 1'b0;
      id_we         = 1'b0;
      wr_addr       = fill_ff[IDX_W-1:0];
      key_wdata     = val_ff;
      id_wdata      = side_ff;

      // response taken downstream
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in     = req_ch.mode;
               val_in      = req_ch.ref_value;
               side_in     = req_ch.read_side;
               base_in     = scope_base_ff[level_ff];
               scan_ptr_in = scope_base_ff[level_ff];
               rd_vld_in   = 1'b0;
               hit_in      = 1'b0;
               res_in      = '0;
               new_in      = 1'b0;
               status_in   = STAT_OK;
               state_in    = S_DONE;
               case (req_ch.mode)
                  MODE_INTERN, MODE_ADD: begin
                     state_in = S_SCAN;
                  end
                  MODE_RES_CHK, MODE_RES: begin
                     // -1 passes straight through
                     if (req_ch.ref_value == REF_NONE) begin
                        res_in = REF_NONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_PUSH: begin
                     if (level_ff == LVL_W'(SCOPES - 1)) begin
                        status_in = STAT_OVERFLOW;
                     end else begin
                        level_in = LVL_W'(level_ff + 1'b1);
                        scope_base_in[LVL_W'(level_ff + 1'b1)] = fill_ff;
                     end
                  end
                  MODE_POP: begin
                     if (level_ff == '0) begin
                        status_in = STAT_UNDERFLOW;
                     end else begin
                        fill_in  = scope_base_ff[level_ff];
                        level_in = LVL_W'(level_ff - 1'b1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read a cycle over the top scope
            if (more_to_read) begin
               rd_en       = 1'b1;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_ptr_ff[IDX_W-1:0];
               scan_ptr_in = CNT_W'(scan_ptr_ff + 1'b1);
            end else begin
               rd_vld_in = 1'b0;
            end

            if (is_resolve) begin
               // keep the smallest signed key carrying the identifier
               if (rd_vld_ff && cmp_eq && (!hit_ff || key_less)) begin
                  best_in = $signed(key_rd_ff);
                  hit_in  = 1'b1;
               end
               if (scan_done) begin
                  state_in = S_DONE;
                  if (hit_ff) begin
                     res_in = best_ff;
                  end else begin
                     res_in    = REF_NONE;
                     status_in = STAT_NOT_FOUND;
                     if (mode_ff == MODE_RES_CHK) begin
                        failed_in = 1'b1;
                     end
                  end
               end
            end else if (rd_vld_ff && cmp_eq) begin
               // key already present in the top scope
               state_in  = S_DONE;
               rd_vld_in = 1'b0;
               if (is_intern) begin
                  res_in = id_rd_ff;
               end else begin
                  id_we   = 1'b1;
                  wr_addr = rd_idx_ff;
               end
            end else if (scan_done) begin
               state_in = S_DONE;
               if (fill_ff == CNT_W'(ENTRIES)) begin
                  status_in = STAT_FULL;
               end else begin
                  key_we   = 1'b1;
                  id_we    = 1'b1;
                  id_wdata = is_intern ? next_id : side_ff;
                  fill_in  = CNT_W'(fill_ff + 1'b1);
                  new_in   = 1'b1;
                  res_in   = is_intern ? next_id : '0;
               end
            end
         end

         S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_res_in    = res_ff;
               rsp_new_in    = new_ff;
               rsp_status_in = status_ff;
               rsp_failed_in = failed_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         level_ff     <= '0;
         failed_ff    <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SCOPES; s++) begin
            scope_base_ff[s] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         level_ff      <= level_in;
         failed_ff     <= failed_in;
         rd_vld_ff     <= rd_vld_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
         scope_base_ff <= scope_base_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      val_ff        <= val_in;
      side_ff       <= side_in;
      base_ff       <= base_in;
      scan_ptr_ff   <= scan_ptr_in;
      rd_idx_ff     <= rd_idx_in;
      best_ff       <= best_in;
      res_ff        <= res_in;
      new_ff        <= new_in;
      status_ff     <= status_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   // key and identifier memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_wdata;
      end
      if (id_we) begin
         id_mem[wr_addr] <= id_wdata;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         id_rd_ff  <= id_mem[rd_addr];
      end
   end

   `SRIT_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= CNT_W'(ENTRIES), "fill pointer beyond table")
   `SRIT_ASSERT_NOW(a_base_le_fill, 1'b1, scope_base_ff[level_ff] <= fill_ff, "scope base past fill")
   `SRIT_ASSERT_NOW(a_scan_bound, state_ff == S_SCAN, scan_ptr_ff <= fill_ff, "scan ran past fill")
   `SRIT_ASSERT_NEXT(a_busy_after_accept, accept, state_ff != S_IDLE, "idle right after request")
   `SRIT_ASSERT_NEXT(a_failed_sticky, failed_ff, failed_ff, "failed flag cleared")

endmodule
